@@ rtl/core/stfs_pkg.sv @@
// Shared types and constants for the sorted table floor search block
`default_nettype none

package stfs_pkg;

    localparam int unsigned TABLE_DEPTH_DEFAULT = 1024;

    localparam int unsigned INDEX_W = 10;
    localparam int unsigned ADDR_W  = 64;
    localparam int unsigned TOTAL_W = 11;
    localparam int unsigned TDATA_W = ((INDEX_W + ADDR_W + 7) / 8) * 8;
    localparam int unsigned PAD_W   = TDATA_W - INDEX_W - ADDR_W;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIRST,
        ST_PROBE,
        ST_DONE
    } stfs_state_t;

    typedef struct packed {
        logic load;
        logic start;
        logic first;
        logic probe;
        logic finish;
    } stfs_cmd_t;

    typedef struct packed {
        logic empty;
        logic pass;
        logic more;
        logic out_busy;
    } stfs_status_t;

endpackage

`default_nettype wire

@@ rtl/core/stfs_ctrl.sv @@
// Sequencer for table loads and the probe loop of a query
`default_nettype none

module stfs_ctrl
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  s_tvalid,
    input  wire                  mode,
    output logic                 s_tready,
    input  stfs_pkg::stfs_status_t status,
    output stfs_pkg::stfs_cmd_t  cmd
);
    import stfs_pkg::*;

    stfs_state_t state_reg;
    stfs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (mode == MODE_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = status.empty ? ST_DONE : ST_FIRST;
                    end
                end
            end
            ST_FIRST:
            begin
                cmd.first = 1'b1;
                if (!status.pass || !status.more)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                cmd.probe = 1'b1;
                if (!status.more)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/stfs_dpath.sv @@
// Table memory, search bounds, candidate and output register
`default_nettype none

module stfs_dpath
#(
    parameter int unsigned TABLE_DEPTH = stfs_pkg::TABLE_DEPTH_DEFAULT
)
(
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_valid,
    input  wire  [stfs_pkg::TOTAL_W-1:0]  cfg_data,
    input  wire  [stfs_pkg::INDEX_W-1:0]  entry_index,
    input  wire  [stfs_pkg::ADDR_W-1:0]   address,
    input  stfs_pkg::stfs_cmd_t           cmd,
    output stfs_pkg::stfs_status_t        status,
    output logic                          out_valid,
    input  wire                           out_ready,
    output logic                          found,
    output logic [stfs_pkg::INDEX_W-1:0]  match_index,
    output logic [stfs_pkg::ADDR_W-1:0]   offset
);
    import stfs_pkg::*;

    localparam int unsigned IW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    logic [ADDR_W-1:0]  mem [TABLE_DEPTH];
    logic [ADDR_W-1:0]  rdata_reg;

    logic [TOTAL_W-1:0] entry_total_reg;
    logic [ADDR_W-1:0]  key_reg;
    logic [CW-1:0]      lo_reg;
    logic [CW-1:0]      hip1_reg;
    logic [IW-1:0]      mid_reg;
    logic [IW-1:0]      cand_reg;
    logic [ADDR_W-1:0]  cand_addr_reg;
    logic               found_reg;

    logic               out_valid_reg;
    logic               out_found_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic [ADDR_W-1:0]  out_offset_reg;

    logic [CW-1:0]      n_cnt;
    logic               pass;
    logic [CW-1:0]      lo_next;
    logic [CW-1:0]      hip1_next;
    logic [CW:0]        mid_sum;
    logic [IW-1:0]      mid_next;
    logic               more;
    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    logic               slot_ok;

    always_comb
    begin
        if (32'(entry_total_reg) > 32'(TABLE_DEPTH))
        begin
            n_cnt = CW'(TABLE_DEPTH);
        end
        else
        begin
            n_cnt = CW'(entry_total_reg);
        end
    end

    assign pass    = (rdata_reg <= key_reg);
    assign slot_ok = (32'(entry_index) < 32'(TABLE_DEPTH));

    always_comb
    begin
        lo_next   = lo_reg;
        hip1_next = hip1_reg;
        if (cmd.first)
        begin
            lo_next   = '0;
            hip1_next = n_cnt;
        end
        else if (cmd.probe)
        begin
            if (pass)
            begin
                lo_next = CW'(mid_reg) + CW'(1);
            end
            else
            begin
                hip1_next = CW'(mid_reg);
            end
        end
    end

    // floor((lo + hi) / 2) with hi = hip1 - 1
    assign mid_sum  = {1'b0, lo_next} + {1'b0, hip1_next} - (CW + 1)'(1);
    assign mid_next = mid_sum[IW:1];
    assign more     = (lo_next < hip1_next);

    assign rd_en   = cmd.start | cmd.first | cmd.probe;
    assign rd_addr = cmd.start ? '0 : mid_next;

    always_ff @(posedge clk)
    begin
        if (cmd.load && slot_ok)
        begin
            mem[IW'(entry_index)] <= address;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_total_reg <= '0;
        end
        else if (cfg_valid)
        begin
            entry_total_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg   <= address;
            found_reg <= 1'b0;
        end
        if (cmd.first || cmd.probe)
        begin
            lo_reg   <= lo_next;
            hip1_reg <= hip1_next;
            mid_reg  <= mid_next;
        end
        if (cmd.first)
        begin
            found_reg     <= pass;
            cand_reg      <= '0;
            cand_addr_reg <= rdata_reg;
        end
        else if (cmd.probe && pass)
        begin
            cand_reg      <= mid_reg;
            cand_addr_reg <= rdata_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_found_reg  <= found_reg;
            out_index_reg  <= found_reg ? INDEX_W'(cand_reg) : '0;
            out_offset_reg <= found_reg ? (key_reg - cand_addr_reg) : '0;
        end
    end

    assign status.empty    = (n_cnt == '0);
    assign status.pass     = pass;
    assign status.more     = more;
    assign status.out_busy = out_valid_reg & ~out_ready;

    assign out_valid   = out_valid_reg;
    assign found       = out_found_reg;
    assign match_index = out_index_reg;
    assign offset      = out_offset_reg;

endmodule

`default_nettype wire

@@ rtl/core/sorted_table_floor_search.sv @@
// Sorted table floor search: top level
//
// Input stream s_*: a transfer with s_tuser = 0 loads s_tdata address into the
// table slot given by entry_index (slots at or above TABLE_DEPTH are dropped);
// s_tuser = 1 is a query whose address is the key. Loads give no result.
// cfg_*: writes entry_total, the count of valid sorted entries (saturates at
// TABLE_DEPTH). Write it only while no query is in flight.
// Output stream m_*: one transfer per query with found in m_tuser, the index of
// the last entry not above the key and key minus that entry address in m_tdata.
// Loads are taken back to back while idle. A query reads and tests entry zero,
// then runs binary probes of the table RAM (at most floor(log2(count))+1
// probes), then registers the result. Queries are serialised. While a result
// waits in the output register, loads and the next query are still taken; a
// query then holds in its final step until m_tready frees the register. Reset
// clears entry_total and the control; table contents are undefined until
// loaded.
`default_nettype none

module sorted_table_floor_search
#(
    parameter int unsigned TABLE_DEPTH = stfs_pkg::TABLE_DEPTH_DEFAULT
)
(
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           s_tvalid,
    output logic                          s_tready,
    input  wire  [stfs_pkg::TDATA_W-1:0]  s_tdata,  // entry_index, address
    input  wire  [0:0]                    s_tuser,  // mode
    output logic                          m_tvalid,
    input  wire                           m_tready,
    output logic [stfs_pkg::TDATA_W-1:0]  m_tdata,  // match_index, offset
    output logic [0:0]                    m_tuser,  // found
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire  [stfs_pkg::TOTAL_W-1:0]  cfg_data
);
    import stfs_pkg::*;

    stfs_cmd_t          cmd;
    stfs_status_t       status;
    logic               found;
    logic [INDEX_W-1:0] match_index;
    logic [ADDR_W-1:0]  offset;

    assign cfg_ready = 1'b1;

    stfs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .mode     (s_tuser[0]),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    stfs_dpath
    #(
        .TABLE_DEPTH (TABLE_DEPTH)
    )
    u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .entry_index (s_tdata[INDEX_W-1:0]),
        .address     (s_tdata[INDEX_W+ADDR_W-1:INDEX_W]),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .found       (found),
        .match_index (match_index),
        .offset      (offset)
    );

    assign m_tdata = {{PAD_W{1'b0}}, offset, match_index};
    assign m_tuser = found;

    a_cmd_onehot : assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.start, cmd.first, cmd.probe, cmd.finish}))
        else $error("more than one datapath command at once");

    a_query_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser[0] == MODE_QUERY) |=> !s_tready)
        else $error("input taken while a query is in flight");

    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(m_tvalid && !m_tready))
        else $error("result register overwritten before transfer");

    a_not_found_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("not-found result carries non-zero data");

endmodule

`default_nettype wire
